// ===== hw/rtl/trilinear_periodic_interp_defines.svh =====
// Assertion macros for the trilinear periodic interpolator.
`ifndef TRILINEAR_PERIODIC_INTERP_DEFINES_SVH
`define TRILINEAR_PERIODIC_INTERP_DEFINES_SVH
// Check a property while out of reset.
`define TPI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("trilinear_periodic_interp assertion failed");
// Check a property at every edge, reset included.
`define TPI_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("trilinear_periodic_interp reset assertion failed");
`endif

// ===== hw/rtl/tpi_pkg.sv =====
// Shared types, constants and helpers for the trilinear periodic interpolator.
`timescale 1ns / 1ps
package tpi_pkg;
  localparam int MAX_POINTS  = 32768;
  localparam int ADDR_W      = $clog2(MAX_POINTS);
  localparam int SAMPLE_BITS = 16;
  localparam int CELL_W      = 5;
  localparam int SIZE_W      = 6;
  localparam int FRAC_W      = 16;
  localparam int WT_W        = FRAC_W + 1;
  localparam int PLANE_W     = 10;
  localparam int CFG_IDX_W   = 2;
  localparam int QDEPTH      = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;

  localparam logic [SIZE_W-1:0] SIZE_MAX = 6'd32;

  typedef enum logic [1:0] {
    ST_INTERP = 2'd0,
    ST_WRITE  = 2'd1,
    ST_RANGE  = 2'd2
  } status_t;

  typedef struct packed {
    status_t                 kind;
    logic [ADDR_W-1:0]       point_index;
    logic [SAMPLE_BITS-1:0]  samp_z;
    logic [SAMPLE_BITS-1:0]  samp_y;
    logic [SAMPLE_BITS-1:0]  samp_x;
    logic [CELL_W-1:0]       i0;
    logic [CELL_W-1:0]       i1;
    logic [CELL_W-1:0]       j0;
    logic [CELL_W-1:0]       j1;
    logic [PLANE_W-1:0]      plane0;
    logic [PLANE_W-1:0]      plane1;
    logic [SIZE_W-1:0]       size_x;
    logic [FRAC_W-1:0]       fx;
    logic [FRAC_W-1:0]       fy;
    logic [FRAC_W-1:0]       fz;
  } job_t;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    r = s;
    if (s == '0) r = 6'd1;
    else if (s > SIZE_MAX) r = SIZE_MAX;
    return r;
  endfunction

  function automatic logic [CELL_W-1:0] up_index(input logic [CELL_W-1:0] i,
                                                 input logic [SIZE_W-1:0] n);
    logic [SIZE_W-1:0] nx;
    nx = {1'b0, i} + 6'd1;
    return (nx >= n) ? '0 : nx[CELL_W-1:0];
  endfunction
endpackage

// ===== hw/rtl/tpi_front.sv =====
// Front end: classify an incoming word and precompute its corner indices.
`timescale 1ns / 1ps
module tpi_front (
  input  logic                             in_action,
  input  logic [tpi_pkg::ADDR_W-1:0]       in_point_index,
  input  logic [tpi_pkg::SAMPLE_BITS-1:0]  in_sample_x,
  input  logic [tpi_pkg::SAMPLE_BITS-1:0]  in_sample_y,
  input  logic [tpi_pkg::SAMPLE_BITS-1:0]  in_sample_z,
  input  logic [tpi_pkg::CELL_W-1:0]       in_cell_x,
  input  logic [tpi_pkg::CELL_W-1:0]       in_cell_y,
  input  logic [tpi_pkg::CELL_W-1:0]       in_cell_z,
  input  logic [tpi_pkg::FRAC_W-1:0]       in_frac_x,
  input  logic [tpi_pkg::FRAC_W-1:0]       in_frac_y,
  input  logic [tpi_pkg::FRAC_W-1:0]       in_frac_z,
  input  logic [tpi_pkg::SIZE_W-1:0]       size_x,
  input  logic [tpi_pkg::SIZE_W-1:0]       size_y,
  input  logic [tpi_pkg::SIZE_W-1:0]       size_z,
  output tpi_pkg::job_t                    job
);
  logic [tpi_pkg::SIZE_W-1:0]   ex, ey, ez;
  logic [tpi_pkg::CELL_W-1:0]   k1;
  logic [2*tpi_pkg::SIZE_W-1:0] p0, p1;
  logic                         oor;

  always_comb begin
    ex  = tpi_pkg::eff_size(size_x);
    ey  = tpi_pkg::eff_size(size_y);
    ez  = tpi_pkg::eff_size(size_z);
    oor = ({1'b0, in_cell_x} >= ex) || ({1'b0, in_cell_y} >= ey) ||
          ({1'b0, in_cell_z} >= ez);
    k1  = tpi_pkg::up_index(in_cell_z, ez);
    p0  = (2*tpi_pkg::SIZE_W)'(ey * {1'b0, in_cell_z});
    p1  = (2*tpi_pkg::SIZE_W)'(ey * {1'b0, k1});

    job.point_index = in_point_index;
    job.samp_x      = in_sample_x;
    job.samp_y      = in_sample_y;
    job.samp_z      = in_sample_z;
    job.i0          = in_cell_x;
    job.i1          = tpi_pkg::up_index(in_cell_x, ex);
    job.j0          = in_cell_y;
    job.j1          = tpi_pkg::up_index(in_cell_y, ey);
    job.plane0      = p0[tpi_pkg::PLANE_W-1:0];
    job.plane1      = p1[tpi_pkg::PLANE_W-1:0];
    job.size_x      = ex;
    job.fx          = in_frac_x;
    job.fy          = in_frac_y;
    job.fz          = in_frac_z;
    if (!in_action) job.kind = tpi_pkg::ST_WRITE;
    else if (oor) job.kind = tpi_pkg::ST_RANGE;
    else job.kind = tpi_pkg::ST_INTERP;
  end
endmodule

// ===== hw/rtl/tpi_queue.sv =====
// Two-entry job queue between front end and back end.
`timescale 1ns / 1ps
module tpi_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tpi_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output tpi_pkg::job_t head
);
  localparam int PTR_W = $clog2(tpi_pkg::QDEPTH);

  tpi_pkg::job_t    slot_r [tpi_pkg::QDEPTH];
  logic [PTR_W:0]   count_r, count_nxt;
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic             do_push, do_pop;

  assign full    = (count_r == (PTR_W+1)'(tpi_pkg::QDEPTH));
  assign empty   = (count_r == '0);
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_job;
  end
endmodule

// ===== hw/rtl/tpi_back.sv =====
// Back end: grid memory, corner sequencer, blend pipeline and result register.
`timescale 1ns / 1ps
module tpi_back (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   q_empty,
  input  tpi_pkg::job_t                          q_head,
  output logic                                   q_pop,
  output logic                                   out_empty,
  input  logic                                   out_pop,
  output logic signed [tpi_pkg::SAMPLE_BITS-1:0] out_vel_out_x,
  output logic signed [tpi_pkg::SAMPLE_BITS-1:0] out_vel_out_y,
  output logic signed [tpi_pkg::SAMPLE_BITS-1:0] out_vel_out_z,
  output logic [1:0]                             out_status
);
  localparam int SB    = tpi_pkg::SAMPLE_BITS;
  localparam int WORD  = 3 * SB;
  localparam int WXY_W = 2 * tpi_pkg::WT_W - 1;
  localparam int W_W   = WXY_W + tpi_pkg::WT_W - 1;
  localparam int P_W   = W_W + 1 + SB;
  localparam int ACC_W = P_W + 3;
  localparam int ROW_W = tpi_pkg::PLANE_W + 1;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RUN   = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t                    state_r, state_nxt;
  tpi_pkg::job_t             job_r;
  logic [2:0]                corner_r;
  logic                      v1_r, v2_r, v3_r;
  logic [WXY_W-1:0]          wxy_r;
  logic [tpi_pkg::WT_W-1:0]  wz_hold_r;
  logic [W_W-1:0]            w_r;
  logic [WORD-1:0]           grid [tpi_pkg::MAX_POINTS];
  logic [WORD-1:0]           rd_r, d_r;
  logic signed [P_W-1:0]     p_r [3];
  logic signed [ACC_W-1:0]   acc_r [3];
  logic                      out_valid_r;
  logic [SB-1:0]             ox_r, oy_r, oz_r;
  logic [1:0]                ost_r;

  logic                      mem_we, rd_en, start, finish;
  logic [tpi_pkg::ADDR_W-1:0] mem_addr;
  logic [tpi_pkg::CELL_W-1:0] ci, cj;
  logic [tpi_pkg::PLANE_W-1:0] cplane;
  logic [ROW_W-1:0]          row;
  logic [ROW_W+tpi_pkg::SIZE_W-1:0] lin;
  logic [tpi_pkg::WT_W-1:0]  wx, wy, wz;
  logic [tpi_pkg::WT_W-1:0]  gx, gy, gz;
  logic signed [ACC_W-1:0]   rnd [3];

  always_comb begin
    gx     = 17'h10000 - {1'b0, job_r.fx};
    gy     = 17'h10000 - {1'b0, job_r.fy};
    gz     = 17'h10000 - {1'b0, job_r.fz};
    wx     = corner_r[0] ? {1'b0, job_r.fx} : gx;
    wy     = corner_r[1] ? {1'b0, job_r.fy} : gy;
    wz     = corner_r[2] ? {1'b0, job_r.fz} : gz;
    ci     = corner_r[0] ? job_r.i1 : job_r.i0;
    cj     = corner_r[1] ? job_r.j1 : job_r.j0;
    cplane = corner_r[2] ? job_r.plane1 : job_r.plane0;
    row    = {1'b0, cplane} + {{(ROW_W-tpi_pkg::CELL_W){1'b0}}, cj};
    lin    = (ROW_W+tpi_pkg::SIZE_W)'(job_r.size_x * row +
             {{(ROW_W+tpi_pkg::SIZE_W-tpi_pkg::CELL_W){1'b0}}, ci});
    for (int c = 0; c < 3; c++) begin
      rnd[c] = acc_r[c] + (ACC_W'(1) <<< (W_W - 2));
    end
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    rd_en     = 1'b0;
    start     = 1'b0;
    finish    = 1'b0;
    mem_addr  = lin[tpi_pkg::ADDR_W-1:0];
    case (state_r)
      S_IDLE: begin
        if (!q_empty && !out_valid_r) begin
          q_pop = 1'b1;
          case (q_head.kind)
            tpi_pkg::ST_WRITE: begin
              mem_we   = 1'b1;
              mem_addr = q_head.point_index;
            end
            tpi_pkg::ST_RANGE: ;
            default: begin
              start     = 1'b1;
              state_nxt = S_RUN;
            end
          endcase
        end
      end
      S_RUN: begin
        rd_en = 1'b1;
        if (corner_r == 3'd7) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!(v1_r || v2_r || v3_r)) begin
          finish    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) grid[mem_addr] <= {q_head.samp_z, q_head.samp_y, q_head.samp_x};
    else if (rd_en) rd_r <= grid[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      corner_r    <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= rd_en;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      if (start) corner_r <= '0;
      else if (rd_en) corner_r <= corner_r + 1'b1;
      if (q_pop && (q_head.kind != tpi_pkg::ST_INTERP)) out_valid_r <= 1'b1;
      else if (finish) out_valid_r <= 1'b1;
      else if (out_pop) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) job_r <= q_head;
    if (rd_en) begin
      wxy_r     <= WXY_W'(wx * wy);
      wz_hold_r <= wz;
    end
    w_r  <= W_W'(wxy_r * wz_hold_r);
    d_r  <= rd_r;
    for (int c = 0; c < 3; c++) begin
      p_r[c] <= $signed({{(P_W-W_W){1'b0}}, w_r}) *
                $signed({{(P_W-SB){d_r[SB*c+SB-1]}}, d_r[SB*c +: SB]});
      if (start) acc_r[c] <= '0;
      else if (v3_r) acc_r[c] <= acc_r[c] + {{(ACC_W-P_W){p_r[c][P_W-1]}}, p_r[c]};
    end
    if (q_pop && (q_head.kind != tpi_pkg::ST_INTERP)) begin
      ox_r  <= '0;
      oy_r  <= '0;
      oz_r  <= '0;
      ost_r <= q_head.kind;
    end else if (finish) begin
      ox_r  <= rnd[0][W_W-1 +: SB];
      oy_r  <= rnd[1][W_W-1 +: SB];
      oz_r  <= rnd[2][W_W-1 +: SB];
      ost_r <= tpi_pkg::ST_INTERP;
    end
  end

  assign out_empty     = !out_valid_r;
  assign out_vel_out_x = ox_r;
  assign out_vel_out_y = oy_r;
  assign out_vel_out_z = oz_r;
  assign out_status    = ost_r;
endmodule

// ===== hw/rtl/trilinear_periodic_interp.sv =====
// Top level of the trilinear periodic grid interpolator.
// Usage:
//   Input queue side: drive a word on the in_ ports and raise in_push; the
//   word is taken at an edge where in_full is low. Action 0 stores one grid
//   point, action 1 interpolates inside cell (cell_x, cell_y, cell_z).
//   Result queue side: while out_empty is low the oldest result sits on the
//   out_ ports; raise out_pop to take it. A stalled receiver just leaves
//   out_pop low: the result holds and up to two more words queue at the input
//   before in_full rises.
//   Config: write size_x/size_y/size_z through cfg_valid/cfg_index/cfg_data
//   only while the block is idle; cfg_ready is always high.
//   Processing: an interpolation reads its eight corners one per cycle from
//   the single-port grid memory, then drains its multiply pipeline; a store
//   or an out-of-range word needs no grid read. A new word is taken only
//   once the back end is idle and the last result has been popped.
//   Reset: sizes return to 32, queues empty; grid contents are undefined
//   until written.
`timescale 1ns / 1ps
module trilinear_periodic_interp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_push,
  output logic                                   in_full,
  input  logic                                   in_action,
  input  logic [tpi_pkg::ADDR_W-1:0]             in_point_index,
  input  logic signed [tpi_pkg::SAMPLE_BITS-1:0] in_sample_x,
  input  logic signed [tpi_pkg::SAMPLE_BITS-1:0] in_sample_y,
  input  logic signed [tpi_pkg::SAMPLE_BITS-1:0] in_sample_z,
  input  logic [tpi_pkg::CELL_W-1:0]             in_cell_x,
  input  logic [tpi_pkg::CELL_W-1:0]             in_cell_y,
  input  logic [tpi_pkg::CELL_W-1:0]             in_cell_z,
  input  logic [tpi_pkg::FRAC_W-1:0]             in_frac_x,
  input  logic [tpi_pkg::FRAC_W-1:0]             in_frac_y,
  input  logic [tpi_pkg::FRAC_W-1:0]             in_frac_z,
  output logic                                   out_empty,
  input  logic                                   out_pop,
  output logic signed [tpi_pkg::SAMPLE_BITS-1:0] out_vel_out_x,
  output logic signed [tpi_pkg::SAMPLE_BITS-1:0] out_vel_out_y,
  output logic signed [tpi_pkg::SAMPLE_BITS-1:0] out_vel_out_z,
  output logic [1:0]                             out_status,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [tpi_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [tpi_pkg::SIZE_W-1:0]             cfg_data
);
  logic [tpi_pkg::SIZE_W-1:0] size_x_r, size_y_r, size_z_r;
  tpi_pkg::job_t              front_job, head_job;
  logic                       q_empty, q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= tpi_pkg::SIZE_MAX;
      size_y_r <= tpi_pkg::SIZE_MAX;
      size_z_r <= tpi_pkg::SIZE_MAX;
    end else if (cfg_valid) begin
      case (cfg_index)
        tpi_pkg::CFG_SIZE_X: size_x_r <= cfg_data;
        tpi_pkg::CFG_SIZE_Y: size_y_r <= cfg_data;
        tpi_pkg::CFG_SIZE_Z: size_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  tpi_front u_front (
    .in_action      (in_action),
    .in_point_index (in_point_index),
    .in_sample_x    (in_sample_x),
    .in_sample_y    (in_sample_y),
    .in_sample_z    (in_sample_z),
    .in_cell_x      (in_cell_x),
    .in_cell_y      (in_cell_y),
    .in_cell_z      (in_cell_z),
    .in_frac_x      (in_frac_x),
    .in_frac_y      (in_frac_y),
    .in_frac_z      (in_frac_z),
    .size_x         (size_x_r),
    .size_y         (size_y_r),
    .size_z         (size_z_r),
    .job            (front_job)
  );

  tpi_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_push),
    .push_job (front_job),
    .full     (in_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (head_job)
  );

  tpi_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_head        (head_job),
    .q_pop         (q_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_vel_out_x (out_vel_out_x),
    .out_vel_out_y (out_vel_out_y),
    .out_vel_out_z (out_vel_out_z),
    .out_status    (out_status)
  );
endmodule

// ===== hw/rtl/tpi_checker.sv =====
// Port-level checker for the trilinear periodic interpolator, with its bind.
`timescale 1ns / 1ps
`include "trilinear_periodic_interp_defines.svh"
module tpi_checker (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   out_empty,
  input logic                                   out_pop,
  input logic signed [tpi_pkg::SAMPLE_BITS-1:0] out_vel_out_x,
  input logic signed [tpi_pkg::SAMPLE_BITS-1:0] out_vel_out_y,
  input logic signed [tpi_pkg::SAMPLE_BITS-1:0] out_vel_out_z,
  input logic [1:0]                             out_status
);
  logic vel_zero;

  assign vel_zero = (out_vel_out_x == '0) && (out_vel_out_y == '0) &&
                    (out_vel_out_z == '0);

  `TPI_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> out_empty)
  `TPI_ASSERT(a_hold, (!out_empty && !out_pop) |=> (!out_empty && $stable(out_status)))
  `TPI_ASSERT(a_status_code, !out_empty |-> (out_status != 2'd3))
  `TPI_ASSERT(a_zero_vel, (!out_empty && (out_status != 2'd0)) |-> vel_zero)
endmodule

bind trilinear_periodic_interp tpi_checker u_tpi_checker (.*);
